[rtl/fhts_pkg.sv]
package fhts_pkg;

    localparam int STORE_DEPTH  = 12;
    localparam int WINDOW_DEPTH = 5;

    typedef enum logic [3:0] {
        FT_INVALID = 4'd0,
        FT_FLAC    = 4'd1,
        FT_M4A     = 4'd2,
        FT_MP4     = 4'd3,
        FT_MP3     = 4'd4,
        FT_OGG     = 4'd5,
        FT_JSON    = 4'd6,
        FT_HTML    = 4'd7,
        FT_TEXT    = 4'd8
    } t_file_type;

    typedef logic [7:0] t_byte;

    localparam logic [31:0] MAGIC_FLAC = "fLaC";
    localparam logic [31:0] MAGIC_FTYP = "ftyp";
    localparam logic [31:0] BRAND_M4A  = "M4A ";
    localparam logic [31:0] BRAND_M4B  = "M4B ";
    localparam logic [23:0] MAGIC_ID3  = "ID3";
    localparam logic [31:0] MAGIC_OGG  = "OggS";
    localparam logic [39:0] TAG_HTML   = "<html";
    localparam logic [39:0] TAG_DOC    = "<!doc";
    localparam t_byte       SYNC_BYTE  = 8'hff;
    localparam logic [2:0]  SYNC_TOP   = 3'b111;

    function automatic logic is_space_byte(input t_byte b);
        return (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    endfunction

    function automatic logic is_printable_byte(input t_byte b);
        return ((b >= 8'd32) && (b <= 8'd126)) || (b == 8'h0d) || (b == 8'h0a)
            || (b == 8'h09);
    endfunction

    function automatic t_byte to_lower_byte(input t_byte b);
        return ((b >= "A") && (b <= "Z")) ? (b + 8'd32) : b;
    endfunction

endpackage

[rtl/file_head_type_sniffer.sv]
// A last item's input transfer and the earliest transfer of its result on m_axis are
// separated by the input register, then the result register, which drives tvalid.
// Throughput: one byte per cycle unless a last byte waits on a stalled result; each byte
// only updates small counters, flags, the 5-byte markup window and the 12-byte head store
// between the input and result registers. A result stalled on m_axis holds off further input
// only once the next last byte reaches the input register. Reset (i_rst_n low, synchronous)
// empties both registers and clears all counters and flags; after each result they clear again.
module file_head_type_sniffer
    import fhts_pkg::*;
#(
    parameter int HEAD_BYTES = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] byte_valid
    input  logic       s_axis_tlast,   // last_item
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [3:0] file_type, [7:4] zero
);

    localparam int CNT_W = $clog2(HEAD_BYTES + 1);
    localparam int FIL_W = $clog2(WINDOW_DEPTH + 1);

    // input register
    logic       r_in_valid;
    t_byte      r_in_byte;
    logic       r_in_bvalid;
    logic       r_in_last;

    // per-file state
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_prt, n_prt;
    logic [FIL_W-1:0] r_fill, n_fill;
    logic             r_space_done, n_space_done;
    logic             r_zero, n_zero;
    t_byte            r_hdr [STORE_DEPTH];
    t_byte            n_hdr [STORE_DEPTH];
    t_byte            r_win [WINDOW_DEPTH];
    t_byte            n_win [WINDOW_DEPTH];

    // result register
    logic       r_out_valid;
    t_file_type r_out_type;
    t_file_type n_type;

    logic consume;
    logic take;
    logic fin;

    assign consume = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || consume;
    assign take = consume && r_in_bvalid && (r_cnt < CNT_W'(HEAD_BYTES));
    assign fin = consume && r_in_last;

    always_comb begin
        n_cnt        = r_cnt;
        n_prt        = r_prt;
        n_fill       = r_fill;
        n_space_done = r_space_done;
        n_zero       = r_zero;
        n_hdr        = r_hdr;
        n_win        = r_win;
        if (take) begin
            n_cnt = r_cnt + 1'b1;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                if (r_cnt == CNT_W'(k)) begin
                    n_hdr[k] = r_in_byte;
                end
            end
            if (!r_space_done) begin
                if (!is_space_byte(r_in_byte)) begin
                    n_space_done = 1'b1;
                    n_win[0]     = r_in_byte;
                    n_fill       = FIL_W'(1);
                end
            end else if (r_fill < FIL_W'(WINDOW_DEPTH)) begin
                for (int k = 0; k < WINDOW_DEPTH; k++) begin
                    if (r_fill == FIL_W'(k)) begin
                        n_win[k] = r_in_byte;
                    end
                end
                n_fill = r_fill + 1'b1;
            end
            if (r_in_byte == 8'd0) begin
                n_zero = 1'b1;
            end else if (is_printable_byte(r_in_byte)) begin
                n_prt = r_prt + 1'b1;
            end
        end
    end

    // classification on the state after the final byte
    logic [CNT_W+2:0] prt_x5;
    logic [CNT_W+2:0] cnt_x4;
    logic [39:0]      win_low;

    always_comb begin
        prt_x5  = {1'b0, n_prt, 2'b00} + {3'b000, n_prt};
        cnt_x4  = {1'b0, n_cnt, 2'b00};
        win_low = {to_lower_byte(n_win[0]), to_lower_byte(n_win[1]),
                   to_lower_byte(n_win[2]), to_lower_byte(n_win[3]),
                   to_lower_byte(n_win[4])};
        if ((n_cnt >= CNT_W'(4))
                && ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == MAGIC_FLAC)) begin
            n_type = FT_FLAC;
        end else if ((n_cnt >= CNT_W'(STORE_DEPTH))
                && ({n_hdr[4], n_hdr[5], n_hdr[6], n_hdr[7]} == MAGIC_FTYP)) begin
            if (({n_hdr[8], n_hdr[9], n_hdr[10], n_hdr[11]} == BRAND_M4A)
                    || ({n_hdr[8], n_hdr[9], n_hdr[10], n_hdr[11]} == BRAND_M4B)) begin
                n_type = FT_M4A;
            end else begin
                n_type = FT_MP4;
            end
        end else if ((n_cnt >= CNT_W'(3))
                && ({n_hdr[0], n_hdr[1], n_hdr[2]} == MAGIC_ID3)) begin
            n_type = FT_MP3;
        end else if ((n_cnt >= CNT_W'(2)) && (n_hdr[0] == SYNC_BYTE)
                && (n_hdr[1][7:5] == SYNC_TOP)) begin
            n_type = FT_MP3;
        end else if ((n_cnt >= CNT_W'(4))
                && ({n_hdr[0], n_hdr[1], n_hdr[2], n_hdr[3]} == MAGIC_OGG)) begin
            n_type = FT_OGG;
        end else if ((n_fill != '0) && ((n_win[0] == "{") || (n_win[0] == "["))) begin
            n_type = FT_JSON;
        end else if ((n_fill >= FIL_W'(WINDOW_DEPTH))
                && ((win_low == TAG_HTML) || (win_low == TAG_DOC))) begin
            n_type = FT_HTML;
        end else if ((n_cnt != '0) && !n_zero && (prt_x5 > cnt_x4)) begin
            // printable > floor(8n/10) is the same as 5p > 4n
            n_type = FT_TEXT;
        end else begin
            n_type = FT_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte   <= s_axis_tdata;
            r_in_bvalid <= s_axis_tuser;
            r_in_last   <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_cnt        <= '0;
            r_prt        <= '0;
            r_fill       <= '0;
            r_space_done <= 1'b0;
            r_zero       <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_prt        <= n_prt;
            r_fill       <= n_fill;
            r_space_done <= n_space_done;
            r_zero       <= n_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_type <= n_type;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_type};

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(HEAD_BYTES)) && (r_prt <= r_cnt))
        else $error("byte or printable count out of range");

    a_fill_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FIL_W'(WINDOW_DEPTH)) && ((r_fill != '0) == r_space_done))
        else $error("markup window fill disagrees with leading space flag");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_cnt == '0) && (r_fill == '0) && !r_zero && r_out_valid)
        else $error("state not cleared or result not offered after last byte");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_in_valid && r_in_last) |-> !consume)
        else $error("result overwritten while stalled");
`endif

endmodule
